FILE: src/hgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgt_pkg
// Shared types and constants of the tripod gait trajectory generator.
// ----------------------------------------------------------------------------
package hgt_pkg;

  localparam int NUM_LEGS = 6;
  localparam int LEG_W    = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;

  localparam int PHASE_W  = 16;
  localparam int AMP_W    = 10;
  localparam int OUT_W    = 11;
  localparam int SINE_W   = 15;

  localparam int NUM_W    = 32;
  localparam int DEN_W    = 16;
  localparam int QUOT_W   = 17;
  localparam int DIV_STEP = 2;
  localparam int DIV_STAGES = (QUOT_W + DIV_STEP - 1) / DIV_STEP;

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    REG_GAIT_MODE,
    REG_STANCE,
    REG_STRIDE,
    REG_LIFT
  } reg_idx_e;

  typedef struct packed {
    logic [LEG_W-1:0] leg;
    logic             yneg;
    logic             zon;
  } meta_t;

  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [QUOT_W-1:0] num_lo;
    logic [QUOT_W-1:0] quot;
  } div_lane_t;

endpackage

FILE: src/hgt_seg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgt_seg
// Leg phase and segment decode; forms dividend and divisor for the sines.
// ----------------------------------------------------------------------------
module hgt_seg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             vld_i,
  input  logic [hgt_pkg::PHASE_W-1:0]      phase_i,
  input  logic [hgt_pkg::LEG_W-1:0]        leg_i,
  input  logic [hgt_pkg::PHASE_W-1:0]      stance_i,
  output logic                             vld_o,
  output logic [hgt_pkg::DEN_W-1:0]        den_o,
  output logic [hgt_pkg::NUM_W-1:0]        num_y_o,
  output logic [hgt_pkg::NUM_W-1:0]        num_z_o,
  output hgt_pkg::meta_t                   meta_o
);

  logic [15:0] s;
  logic [15:0] t;
  logic [16:0] t2;
  logic [16:0] lim_b;
  logic [15:0] den_b;
  logic [15:0] d;
  logic [16:0] zdiff;
  logic [16:0] sum_c;
  logic [15:0] n;

  logic                        vld_q;
  logic [hgt_pkg::DEN_W-1:0]   den_d, den_q;
  logic [hgt_pkg::NUM_W-1:0]   num_y_d, num_y_q;
  logic [hgt_pkg::NUM_W-1:0]   num_z_d, num_z_q;
  hgt_pkg::meta_t              meta_d, meta_q;

  always_comb begin
    s     = (stance_i == '0) ? 16'd1 : stance_i;
    t     = phase_i + {leg_i[0], 15'b0};
    t2    = {t, 1'b0};
    lim_b = 17'(18'h20000 - {2'b0, s});
    den_b = 16'(17'h10000 - {1'b0, s});
    d     = t[15] ? {1'b0, t[14:0]} : 16'(17'h08000 - {1'b0, t});
    zdiff = t2 - {1'b0, s};
    sum_c = {1'b0, t} + {1'b0, s};
    n     = sum_c[16] ? sum_c[15:0] : 16'd0;
  end

  always_comb begin
    meta_d.leg = leg_i;
    priority if (t2 <= {1'b0, s}) begin
      den_d       = s;
      num_y_d     = {t, 16'b0};
      num_z_d     = '0;
      meta_d.yneg = 1'b1;
      meta_d.zon  = 1'b0;
    end else if (t2 <= lim_b) begin
      den_d       = den_b;
      num_y_d     = {d, 16'b0};
      num_z_d     = {zdiff, 15'b0};
      meta_d.yneg = ~t[15];
      meta_d.zon  = 1'b1;
    end else begin
      den_d       = s;
      num_y_d     = {n, 16'b0};
      num_z_d     = '0;
      meta_d.yneg = 1'b0;
      meta_d.zon  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q   <= den_d;
    num_y_q <= num_y_d;
    num_z_q <= num_z_d;
    meta_q  <= meta_d;
  end

  assign vld_o   = vld_q;
  assign den_o   = den_q;
  assign num_y_o = num_y_q;
  assign num_z_o = num_z_q;
  assign meta_o  = meta_q;

endmodule

FILE: src/hgt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgt_div
// Pipelined restoring divider, two lanes sharing one divisor.
// ----------------------------------------------------------------------------
module hgt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [hgt_pkg::DEN_W-1:0]     den_i,
  input  logic [hgt_pkg::NUM_W-1:0]     num_y_i,
  input  logic [hgt_pkg::NUM_W-1:0]     num_z_i,
  input  hgt_pkg::meta_t                meta_i,
  output logic                          vld_o,
  output logic [hgt_pkg::QUOT_W-1:0]    quot_y_o,
  output logic [hgt_pkg::QUOT_W-1:0]    quot_z_o,
  output hgt_pkg::meta_t                meta_o
);

  localparam int NS = hgt_pkg::DIV_STAGES;
  localparam int QW = hgt_pkg::QUOT_W;
  localparam int DW = hgt_pkg::DEN_W;

  function automatic hgt_pkg::div_lane_t div_steps(input hgt_pkg::div_lane_t a,
                                                   input logic [DW-1:0] den,
                                                   input int first);
    hgt_pkg::div_lane_t r;
    logic [DW:0]        trial;
    r = a;
    for (int j = 0; j < hgt_pkg::DIV_STEP; j++) begin
      if (first + j < QW) begin
        trial = {r.rem, r.num_lo[QW-1-first-j]};
        if (trial >= {1'b0, den}) begin
          r.rem = DW'(trial - {1'b0, den});
          r.quot[QW-1-first-j] = 1'b1;
        end else begin
          r.rem = trial[DW-1:0];
        end
      end
    end
    return r;
  endfunction

  hgt_pkg::div_lane_t init_y, init_z;

  logic               vld_q  [NS];
  logic [DW-1:0]      den_q  [NS];
  hgt_pkg::meta_t     meta_q [NS];
  hgt_pkg::div_lane_t ly_q   [NS];
  hgt_pkg::div_lane_t lz_q   [NS];

  always_comb begin
    init_y.rem    = {1'b0, num_y_i[hgt_pkg::NUM_W-1:QW]};
    init_y.num_lo = num_y_i[QW-1:0];
    init_y.quot   = '0;
    init_z.rem    = {1'b0, num_z_i[hgt_pkg::NUM_W-1:QW]};
    init_z.num_lo = num_z_i[QW-1:0];
    init_z.quot   = '0;
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic               in_vld;
    logic [DW-1:0]      in_den;
    hgt_pkg::meta_t     in_meta;
    hgt_pkg::div_lane_t in_y, in_z;

    if (s == 0) begin : g_first
      assign in_vld  = vld_i;
      assign in_den  = den_i;
      assign in_meta = meta_i;
      assign in_y    = init_y;
      assign in_z    = init_z;
    end else begin : g_next
      assign in_vld  = vld_q[s-1];
      assign in_den  = den_q[s-1];
      assign in_meta = meta_q[s-1];
      assign in_y    = ly_q[s-1];
      assign in_z    = lz_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s]  <= in_den;
      meta_q[s] <= in_meta;
      ly_q[s]   <= div_steps(in_y, in_den, s * hgt_pkg::DIV_STEP);
      lz_q[s]   <= div_steps(in_z, in_den, s * hgt_pkg::DIV_STEP);
    end
  end

  assign vld_o    = vld_q[NS-1];
  assign quot_y_o = ly_q[NS-1].quot;
  assign quot_z_o = lz_q[NS-1].quot;
  assign meta_o   = meta_q[NS-1];

endmodule

FILE: src/hgt_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgt_sine
// Half-turn sine lookup from a quarter-wave table, amplitude scaling, rounding.
// ----------------------------------------------------------------------------
module hgt_sine #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  logic [hgt_pkg::QUOT_W-1:0]          quot_y_i,
  input  logic [hgt_pkg::QUOT_W-1:0]          quot_z_i,
  input  hgt_pkg::meta_t                      meta_i,
  input  logic                                gait_i,
  input  logic [hgt_pkg::AMP_W-1:0]           stride_i,
  input  logic [hgt_pkg::AMP_W-1:0]           lift_i,
  output logic                                vld_o,
  output logic [hgt_pkg::LEG_W-1:0]           leg_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    y_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    z_o
);

  localparam int TABLE_LEN = (1 << SINE_TABLE_BITS) + 1;
  localparam int IDX_W     = SINE_TABLE_BITS + 1;
  localparam int HALF_LSB  = 1 << (14 - SINE_TABLE_BITS);
  localparam int IDX_SHIFT = 15 - SINE_TABLE_BITS;
  localparam int SW        = hgt_pkg::SINE_W;
  localparam int PW        = hgt_pkg::SINE_W + hgt_pkg::AMP_W;
  localparam int OW        = hgt_pkg::OUT_W;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned OneQ30    = 64'd1073741824;

  function automatic logic [SW-1:0] rom_entry(input int i);
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    x    = (HalfPiQ30 * 64'(i)) >> SINE_TABLE_BITS;
    term = x;
    sum  = x;
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32767 + (OneQ30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return SW'(v);
  endfunction

  logic [SW-1:0] sine_rom [TABLE_LEN];

  for (genvar g = 0; g < TABLE_LEN; g++) begin : g_rom
    localparam logic [SW-1:0] ENTRY = rom_entry(g);
    assign sine_rom[g] = ENTRY;
  end

  function automatic logic [IDX_W-1:0] to_index(input logic [hgt_pkg::QUOT_W-1:0] u);
    logic [15:0] fold;
    logic [16:0] sum;
    fold = (u > 17'h08000) ? 16'(17'h10000 - u) : u[15:0];
    sum  = {1'b0, fold} + 17'(HALF_LSB);
    return IDX_W'(sum >> IDX_SHIFT);
  endfunction

  // index stage
  logic                vld1_q;
  hgt_pkg::meta_t      meta1_q;
  logic [IDX_W-1:0]    idx_y_q, idx_z_q;

  // table read stage
  logic                vld2_q;
  hgt_pkg::meta_t      meta2_q;
  logic [SW-1:0]       sin_y_q, sin_z_q;

  // product stage
  logic                vld3_q;
  hgt_pkg::meta_t      meta3_q;
  logic [PW-1:0]       prod_y_q, prod_z_q;

  logic [PW:0]         rnd_y, rnd_z;
  logic [OW-1:0]       mag_y, mag_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    meta1_q  <= meta_i;
    idx_y_q  <= to_index(quot_y_i);
    idx_z_q  <= to_index(quot_z_i);
    meta2_q  <= meta1_q;
    sin_y_q  <= sine_rom[idx_y_q];
    sin_z_q  <= sine_rom[idx_z_q];
    meta3_q  <= meta2_q;
    prod_y_q <= PW'(sin_y_q * stride_i);
    prod_z_q <= PW'(sin_z_q * lift_i);
  end

  always_comb begin
    rnd_y = {1'b0, prod_y_q} + (PW+1)'(16384);
    rnd_z = {1'b0, prod_z_q} + (PW+1)'(16384);
    mag_y = OW'(rnd_y >> 15);
    mag_z = OW'(rnd_z >> 15);
    if (!gait_i) begin
      y_o = '0;
      z_o = '0;
    end else begin
      y_o = meta3_q.yneg ? OW'(11'd0 - mag_y) : mag_y;
      z_o = meta3_q.zon ? mag_z : '0;
    end
  end

  assign vld_o = vld3_q;
  assign leg_o = meta3_q.leg;

endmodule

FILE: src/hexapod_gait_trajectory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexapod_gait_trajectory
// Tripod gait foot trajectory: per leg stride (y) and lift (z) offsets.
// ----------------------------------------------------------------------------
// datapath: legs go one per cycle through one shared datapath (decode,
//   9-stage divider, index, table, multiply); the next transfer is taken
//   during the last leg of the one before
// reset: config registers take their reset values, pipeline valids clear;
//   result registers hold unknown values until the first done_o
// results cannot be stalled; done_o is a one-cycle strobe
module hexapod_gait_trajectory #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hgt_pkg::ADDR_W-1:0]          paddr,
  input  logic [hgt_pkg::DATA_W-1:0]          pwdata,
  output logic [hgt_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic [hgt_pkg::PHASE_W-1:0]         cycle_phase_i,
  output logic                                done_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg0_y_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg0_z_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg1_y_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg1_z_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg2_y_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg2_z_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg3_y_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg3_z_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg4_y_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg4_z_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg5_y_o,
  output logic signed [hgt_pkg::OUT_W-1:0]    leg5_z_o
);

  localparam int LW = hgt_pkg::LEG_W;
  localparam logic [LW-1:0] LAST_LEG = LW'(hgt_pkg::NUM_LEGS - 1);

  // configuration registers
  logic                           gait_q;
  logic [hgt_pkg::PHASE_W-1:0]    stance_q;
  logic [hgt_pkg::AMP_W-1:0]      stride_q;
  logic [hgt_pkg::AMP_W-1:0]      lift_q;
  logic                           cfg_wr;
  hgt_pkg::reg_idx_e              cfg_idx;

  // leg sequencer
  logic                           seq_vld_q;
  logic [LW-1:0]                  seq_leg_q;
  logic [hgt_pkg::PHASE_W-1:0]    seq_phase_q;
  logic                           accept;

  // datapath links
  logic                           seg_vld;
  logic [hgt_pkg::DEN_W-1:0]      seg_den;
  logic [hgt_pkg::NUM_W-1:0]      seg_num_y, seg_num_z;
  hgt_pkg::meta_t                 seg_meta;
  logic                           div_vld;
  logic [hgt_pkg::QUOT_W-1:0]     div_q_y, div_q_z;
  hgt_pkg::meta_t                 div_meta;
  logic                           fin_vld;
  logic [LW-1:0]                  fin_leg;
  logic signed [hgt_pkg::OUT_W-1:0] fin_y, fin_z;

  // result collection
  logic signed [hgt_pkg::OUT_W-1:0] res_y_q [hgt_pkg::NUM_LEGS];
  logic signed [hgt_pkg::OUT_W-1:0] res_z_q [hgt_pkg::NUM_LEGS];
  logic                           done_d, done_q;

  // config port
  assign pready  = 1'b1;
  assign cfg_idx = hgt_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gait_q   <= 1'b0;
      stance_q <= 16'h8000;
      stride_q <= '0;
      lift_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        hgt_pkg::REG_GAIT_MODE: gait_q   <= pwdata[0];
        hgt_pkg::REG_STANCE:    stance_q <= pwdata[hgt_pkg::PHASE_W-1:0];
        hgt_pkg::REG_STRIDE:    stride_q <= pwdata[hgt_pkg::AMP_W-1:0];
        hgt_pkg::REG_LIFT:      lift_q   <= pwdata[hgt_pkg::AMP_W-1:0];
        default:                gait_q   <= gait_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      hgt_pkg::REG_GAIT_MODE: prdata = hgt_pkg::DATA_W'(gait_q);
      hgt_pkg::REG_STANCE:    prdata = hgt_pkg::DATA_W'(stance_q);
      hgt_pkg::REG_STRIDE:    prdata = hgt_pkg::DATA_W'(stride_q);
      hgt_pkg::REG_LIFT:      prdata = hgt_pkg::DATA_W'(lift_q);
      default:                prdata = '0;
    endcase
  end

  // one leg per cycle; the next transfer is taken during the last leg
  assign busy   = seq_vld_q && (seq_leg_q != LAST_LEG);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_vld_q <= 1'b0;
      seq_leg_q <= '0;
    end else if (accept) begin
      seq_vld_q <= 1'b1;
      seq_leg_q <= '0;
    end else if (seq_vld_q) begin
      if (seq_leg_q == LAST_LEG) begin
        seq_vld_q <= 1'b0;
        seq_leg_q <= '0;
      end else begin
        seq_leg_q <= seq_leg_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_phase_q <= cycle_phase_i;
    end
  end

  hgt_seg u_seg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (seq_vld_q),
    .phase_i  (seq_phase_q),
    .leg_i    (seq_leg_q),
    .stance_i (stance_q),
    .vld_o    (seg_vld),
    .den_o    (seg_den),
    .num_y_o  (seg_num_y),
    .num_z_o  (seg_num_z),
    .meta_o   (seg_meta)
  );

  hgt_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (seg_vld),
    .den_i    (seg_den),
    .num_y_i  (seg_num_y),
    .num_z_i  (seg_num_z),
    .meta_i   (seg_meta),
    .vld_o    (div_vld),
    .quot_y_o (div_q_y),
    .quot_z_o (div_q_z),
    .meta_o   (div_meta)
  );

  hgt_sine #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (div_vld),
    .quot_y_i (div_q_y),
    .quot_z_i (div_q_z),
    .meta_i   (div_meta),
    .gait_i   (gait_q),
    .stride_i (stride_q),
    .lift_i   (lift_q),
    .vld_o    (fin_vld),
    .leg_o    (fin_leg),
    .y_o      (fin_y),
    .z_o      (fin_z)
  );

  assign done_d = fin_vld && (fin_leg == LAST_LEG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_vld) begin
      res_y_q[fin_leg] <= fin_y;
      res_z_q[fin_leg] <= fin_z;
    end
  end

  assign done_o   = done_q;
  assign leg0_y_o = res_y_q[0];
  assign leg0_z_o = res_z_q[0];
  assign leg1_y_o = res_y_q[1];
  assign leg1_z_o = res_z_q[1];
  assign leg2_y_o = res_y_q[2];
  assign leg2_z_o = res_z_q[2];
  assign leg3_y_o = res_y_q[3];
  assign leg3_z_o = res_z_q[3];
  assign leg4_y_o = res_y_q[4];
  assign leg4_z_o = res_z_q[4];
  assign leg5_y_o = res_y_q[5];
  assign leg5_z_o = res_z_q[5];

endmodule

FILE: tb/sv/hexapod_gait_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexapod_gait_checker
// Watches the config port and the command channel of the tripod gait
// trajectory generator. It keeps its own copy of the registers, predicts the
// foot offsets of all legs for every accepted cycle phase from a locally built
// quarter-wave sine table, and compares each result strobe field by field with
// the oldest prediction. It reports the failure count and the number of
// predictions still waiting.
// ----------------------------------------------------------------------------
module hexapod_gait_checker #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   psel_i,
  input  logic                                                   penable_i,
  input  logic                                                   pwrite_i,
  input  logic                                                   pready_i,
  input  logic [hgt_pkg::ADDR_W-1:0]                             paddr_i,
  input  logic [hgt_pkg::DATA_W-1:0]                             pwdata_i,
  input  logic                                                   start_i,
  input  logic                                                   busy_i,
  input  logic [hgt_pkg::PHASE_W-1:0]                            cycle_phase_i,
  input  logic                                                   done_i,
  input  logic [2*hgt_pkg::NUM_LEGS-1:0][hgt_pkg::OUT_W-1:0]     offsets_i,
  output int                                                     errors_o,
  output int                                                     pending_o
);
  import hgt_pkg::*;

  localparam int TABLE_LEN = (1 << SINE_TABLE_BITS) + 1;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  typedef logic [2*NUM_LEGS-1:0][OUT_W-1:0] offsets_t;

  int unsigned quarter_sine [TABLE_LEN];

  logic             gait_on;
  logic [15:0]      stance_q16;
  logic [AMP_W-1:0] stride_amp;
  logic [AMP_W-1:0] lift_amp;

  offsets_t expected_offsets [$];
  int       fail_count;

  // quarter-wave table, integer taylor series in q2.30
  initial begin : build_table
    longint unsigned x, term, sum, v;
    for (int i = 0; i < TABLE_LEN; i++) begin
      x    = (HALF_PI_Q30 * longint'(i)) >> SINE_TABLE_BITS;
      term = x;
      sum  = x;
      for (int k = 1; k <= 8; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = (sum > term) ? sum - term : 0;
        else sum = sum + term;
      end
      v = (sum * 32767 + (ONE_Q30 >> 1)) >> 30;
      if (v > 32767) v = 32767;
      quarter_sine[i] = int'(v);
    end
  end

  // sine of pi*u/65536, q1.15 magnitude
  function automatic int unsigned half_turn_sine(longint unsigned u);
    longint unsigned idx;
    if (u > 65536) u = 65536;
    if (u > 32768) u = 65536 - u;
    idx = ((u << SINE_TABLE_BITS) + 16384) >> 15;
    if (idx >= TABLE_LEN) idx = TABLE_LEN - 1;
    return quarter_sine[idx];
  endfunction

  function automatic logic [OUT_W-1:0] scaled(int unsigned sine, bit neg,
                                               logic [AMP_W-1:0] amp);
    longint unsigned  m;
    logic [OUT_W-1:0] r;
    m = (longint'(sine) * longint'(amp) + 16384) >> 15;
    r = m[OUT_W-1:0];
    if (neg) r = -r;
    return r;
  endfunction

  function automatic offsets_t foot_offsets(logic [PHASE_W-1:0] phase);
    offsets_t        r;
    longint unsigned s, t, den, d, n, ys, zs;
    bit              yneg;
    r = '0;
    if (!gait_on) return r;
    s = (stance_q16 == 16'd0) ? 1 : longint'(stance_q16);
    for (int leg = 0; leg < NUM_LEGS; leg++) begin
      t    = (longint'(phase) + ((leg % 2 == 1) ? 32768 : 0)) % 65536;
      ys   = 0;
      zs   = 0;
      yneg = 1'b0;
      if (2 * t <= s) begin
        ys   = half_turn_sine((t << 16) / s);
        yneg = 1'b1;
      end else if (2 * t <= 131072 - s) begin
        den  = 65536 - s;
        d    = (t >= 32768) ? t - 32768 : 32768 - t;
        ys   = half_turn_sine((d << 16) / den);
        yneg = (t < 32768);
        zs   = half_turn_sine(((2 * t - s) << 15) / den);
      end else begin
        n  = (t + s >= 65536) ? t + s - 65536 : 0;
        ys = half_turn_sine((n << 16) / s);
      end
      r[2*leg]   = scaled(int'(ys), yneg, stride_amp);
      r[2*leg+1] = scaled(int'(zs), 1'b0, lift_amp);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    offsets_t want;
    if (!rst_ni) begin
      gait_on    = 1'b0;
      stance_q16 = 16'd32768;
      stride_amp = '0;
      lift_amp   = '0;
      fail_count = 0;
      expected_offsets.delete();
    end else begin
      if (done_i) begin
        if (expected_offsets.size() == 0) begin
          if (fail_count < 10) $display("result transfer with no prediction waiting");
          fail_count++;
        end else begin
          want = expected_offsets.pop_front();
          for (int f = 0; f < 2 * NUM_LEGS; f++) begin
            if (offsets_i[f] !== want[f]) begin
              if (fail_count < 10) begin
                $display("leg%0d_%s mismatch: expected %0d, got %0d", f / 2,
                         (f % 2 == 1) ? "z" : "y", $signed(want[f]),
                         $signed(offsets_i[f]));
              end
              fail_count++;
            end
          end
        end
      end
      if (start_i && !busy_i) expected_offsets.push_back(foot_offsets(cycle_phase_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_GAIT_MODE: gait_on    = pwdata_i[0];
          REG_STANCE:    stance_q16 = pwdata_i[15:0];
          REG_STRIDE:    stride_amp = pwdata_i[AMP_W-1:0];
          REG_LIFT:      lift_amp   = pwdata_i[AMP_W-1:0];
          default: ;
        endcase
      end
    end
    errors_o  <= fail_count;
    pending_o <= expected_offsets.size();
  end

endmodule

FILE: tb/sv/hexapod_gait_trajectory_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexapod_gait_trajectory_test
// Drives the tripod gait trajectory generator: register writes over the
// config port between phases, a short directed set of cycle phases around
// the segment boundaries and register extremes, then random phases under
// random settings with random start gaps. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module hexapod_gait_trajectory_test;
  import hgt_pkg::*;

  localparam int DRAIN_CYCLES = 25;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [DATA_W-1:0]   pwdata        = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                start         = 1'b0;
  logic                busy;
  logic [PHASE_W-1:0]  cycle_phase   = '0;
  logic                done_o;
  logic [2*NUM_LEGS-1:0][OUT_W-1:0] offsets;
  int                  errors;
  int                  pending;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hexapod_gait_trajectory DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .cycle_phase_i (cycle_phase),
    .done_o        (done_o),
    .leg0_y_o      (offsets[0]),
    .leg0_z_o      (offsets[1]),
    .leg1_y_o      (offsets[2]),
    .leg1_z_o      (offsets[3]),
    .leg2_y_o      (offsets[4]),
    .leg2_z_o      (offsets[5]),
    .leg3_y_o      (offsets[6]),
    .leg3_z_o      (offsets[7]),
    .leg4_y_o      (offsets[8]),
    .leg4_z_o      (offsets[9]),
    .leg5_y_o      (offsets[10]),
    .leg5_z_o      (offsets[11])
  );

  hexapod_gait_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .start_i       (start),
    .busy_i        (busy),
    .cycle_phase_i (cycle_phase),
    .done_i        (done_o),
    .offsets_i     (offsets),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  task automatic reg_write(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // wait until every predicted transfer has arrived and the datapath is empty
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic gait, input logic [15:0] stance,
                           input logic [AMP_W-1:0] stride, input logic [AMP_W-1:0] lift);
    settle();
    reg_write(REG_GAIT_MODE, DATA_W'(gait));
    reg_write(REG_STANCE, DATA_W'(stance));
    reg_write(REG_STRIDE, DATA_W'(stride));
    reg_write(REG_LIFT, DATA_W'(lift));
  endtask

  task automatic send_phase(input logic [PHASE_W-1:0] phase, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start       = 1'b1;
    cycle_phase = phase;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [AMP_W-1:0] pick_amplitude();
    if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) == 1) ? 10'd1023 : 10'd0;
    return AMP_W'($urandom_range(0, 1023));
  endfunction

  // half the phases land next to a segment boundary of either leg group
  function automatic logic [PHASE_W-1:0] pick_phase(input logic [15:0] stance);
    int          kind;
    logic [15:0] bound;
    kind = $urandom_range(0, 3);
    if (kind < 2) return PHASE_W'($urandom);
    bound = (kind == 2) ? (stance >> 1) : (16'd0 - (stance >> 1));
    bound = bound + 16'($urandom_range(0, 4)) - 16'd2;
    if ($urandom_range(0, 1) == 1) bound = bound + 16'h8000;
    return bound;
  endfunction

  initial begin
    logic [15:0] stance;
    bit          calm;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // stance mode out of reset, then with full amplitudes
    send_phase(16'd0, 0);
    send_phase(16'hFFFF, 1);
    configure(1'b0, 16'd32768, 10'd1023, 10'd1023);
    send_phase(16'd16384, 0);
    send_phase(16'd49151, 0);

    configure(1'b1, 16'd32768, 10'd1023, 10'd1023);
    send_phase(16'd0, 0);
    send_phase(16'd1, 0);
    send_phase(16'd16383, 2);
    send_phase(16'd16384, 0);
    send_phase(16'd32767, 4);
    send_phase(16'd32768, 0);
    send_phase(16'd49152, 1);
    send_phase(16'd8192, 0);
    send_phase(16'hFFFF, 0);

    // zero stance fraction saturates to the lowest legal value
    configure(1'b1, 16'd0, 10'd1023, 10'd511);
    send_phase(16'd0, 0);
    send_phase(16'd1, 3);
    send_phase(16'd2, 0);
    send_phase(16'd32768, 0);
    send_phase(16'hFFFF, 2);

    configure(1'b1, 16'hFFFF, 10'd1023, 10'd1023);
    send_phase(16'd32767, 0);
    send_phase(16'd32768, 0);
    send_phase(16'd32769, 1);
    send_phase(16'd0, 0);

    configure(1'b1, 16'd1, 10'd700, 10'd1023);
    send_phase(16'd0, 0);
    send_phase(16'd32768, 4);
    send_phase(16'd16384, 0);

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 4))
        0:       stance = 16'd0;
        1:       stance = 16'd1;
        2:       stance = 16'hFFFF;
        3:       stance = 16'd32768;
        default: stance = 16'($urandom_range(1, 65535));
      endcase
      configure(p != 5, stance, pick_amplitude(), pick_amplitude());
      calm = 1'b0;
      for (int k = 0; k < 60; k++) begin
        if (k % 20 == 0) calm = ($urandom_range(0, 2) == 0);
        send_phase(pick_phase(stance), calm ? 0 : $urandom_range(0, 4));
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("** hexapod_gait_trajectory: PASSED **");
    end else begin
      $display("** hexapod_gait_trajectory: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** hexapod_gait_trajectory: FAILED **");
    $finish;
  end

endmodule
